// File: rtl/core/mdec_pkg.sv
// Package: opcode, function and memory-width codes for the decode stage.
`timescale 1ns / 1ps

package mdec_pkg;

   localparam int unsigned WordWidth = 32;
   localparam int unsigned RegIdxWidth = 5;
   localparam int unsigned ImmWidth = 16;

   typedef logic [5:0] opcode_type;
   typedef logic [2:0] mem_width_type;

   localparam opcode_type OP_R     = 6'h00;
   localparam opcode_type OP_J     = 6'h02;
   localparam opcode_type OP_JAL   = 6'h03;
   localparam opcode_type OP_BEQ   = 6'h04;
   localparam opcode_type OP_BNE   = 6'h05;
   localparam opcode_type OP_BGTZ  = 6'h07;
   localparam opcode_type OP_ADDI  = 6'h08;
   localparam opcode_type OP_ADDIU = 6'h09;
   localparam opcode_type OP_SLTI  = 6'h0A;
   localparam opcode_type OP_ANDI  = 6'h0C;
   localparam opcode_type OP_ORI   = 6'h0D;
   localparam opcode_type OP_NORI  = 6'h0E;
   localparam opcode_type OP_LUI   = 6'h0F;
   localparam opcode_type OP_LB    = 6'h20;
   localparam opcode_type OP_LH    = 6'h21;
   localparam opcode_type OP_LW    = 6'h23;
   localparam opcode_type OP_LBU   = 6'h24;
   localparam opcode_type OP_LHU   = 6'h25;
   localparam opcode_type OP_SB    = 6'h28;
   localparam opcode_type OP_SH    = 6'h29;
   localparam opcode_type OP_SW    = 6'h2B;
   localparam opcode_type OP_HALT  = 6'h3F;

   localparam opcode_type FN_JR    = 6'h08;

   localparam logic [RegIdxWidth-1:0] LINK_REG = 5'd31;

   localparam mem_width_type MW_WORD  = 3'd0;
   localparam mem_width_type MW_HALF  = 3'd1;
   localparam mem_width_type MW_BYTE  = 3'd2;
   localparam mem_width_type MW_HALFU = 3'd3;
   localparam mem_width_type MW_BYTEU = 3'd4;
   localparam mem_width_type MW_NONE  = 3'd5;

endpackage

// File: rtl/core/mips_decode_stage_with_branch_resolve.sv
// Top level: MIPS instruction decode with operand forwarding and branch resolve.
`timescale 1ns / 1ps
//
// Usage
//   Request channel: drive the req_ fields and raise start; the item is taken
//   at a rising edge where start is high and busy is low. busy is high only
//   from a reset edge until the first edge without reset; otherwise an item
//   may be offered every cycle.
//   Result channel: rsp_valid is high for one cycle with the decoded item on
//   the rsp_ ports; the receiver takes it at the end of that cycle and cannot
//   hold it off.
//   Path: the accepted item passes the input register, then the decode logic
//   into the result register.
//   Throughput: one item per cycle while busy is low; the decode and branch
//   compare/add sit in one stage between the input and result registers.
//   Reset (synchronous, active high): drops any item in flight, clears
//   rsp_valid and raises busy; no other state is kept.
//   A squashed item yields a result with every field zero.
//
module mips_decode_stage_with_branch_resolve (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   output logic                                  busy,
   input  logic [mdec_pkg::WordWidth-1:0]        req_instruction,
   input  logic [mdec_pkg::WordWidth-1:0]        req_pc_plus_four,
   input  logic [mdec_pkg::WordWidth-1:0]        req_rs_regval,
   input  logic [mdec_pkg::WordWidth-1:0]        req_rt_regval,
   input  logic                                  req_fwd_rs,
   input  logic                                  req_fwd_rt,
   input  logic [mdec_pkg::WordWidth-1:0]        req_ex_alu_result,
   input  logic                                  req_squash,
   output logic                                  rsp_valid,
   output logic [mdec_pkg::WordWidth-1:0]        rsp_rs_value,
   output logic [mdec_pkg::WordWidth-1:0]        rsp_rt_value,
   output logic signed [mdec_pkg::ImmWidth-1:0]  rsp_imm_ext,
   output logic [mdec_pkg::RegIdxWidth-1:0]      rsp_dest_reg,
   output logic                                  rsp_alu_src,
   output logic                                  rsp_mem_read,
   output logic                                  rsp_mem_write,
   output mdec_pkg::mem_width_type               rsp_mem_width,
   output logic                                  rsp_reg_write,
   output logic                                  rsp_branch_taken,
   output logic [mdec_pkg::WordWidth-1:0]        rsp_branch_target,
   output logic                                  rsp_halt
);
   import mdec_pkg::*;

   logic                    busy_ff;
   logic                    in_valid_ff;
   logic [WordWidth-1:0]    ins_ff, pc4_ff, rsv_ff, rtv_ff, exr_ff;
   logic                    fwd_rs_ff, fwd_rt_ff, squash_ff;

   logic                    accept;

   logic [WordWidth-1:0]    rs_value_in, rt_value_in, target_in;
   logic [ImmWidth-1:0]     imm_in;
   logic [RegIdxWidth-1:0]  dest_in;
   logic                    src_imm_in, mread_in, mwrite_in, rwrite_in, taken_in, halt_in;
   mem_width_type           width_in;

   logic                    rsp_valid_ff;
   logic [WordWidth-1:0]    rs_value_ff, rt_value_ff, target_ff;
   logic [ImmWidth-1:0]     imm_ff;
   logic [RegIdxWidth-1:0]  dest_ff;
   logic                    alu_src_ff, mread_ff, mwrite_ff, rwrite_ff, taken_ff, halt_ff;
   mem_width_type           width_ff;

   // decode scratch
   opcode_type              op, fn;
   logic [WordWidth-1:0]    a, b, imm32, btarget, jtarget;
   logic                    d_alu_src, d_mread, d_mwrite, d_rwrite, d_taken;
   logic [RegIdxWidth-1:0]  d_dest;
   logic [WordWidth-1:0]    d_target;
   mem_width_type           d_width;

   assign accept = start & ~busy_ff;
   assign busy   = busy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b1;
         in_valid_ff <= 1'b0;
      end else begin
         busy_ff     <= 1'b0;
         in_valid_ff <= accept;
      end
   end

   // hold the payload unless a new item is taken
   always_ff @(posedge clock) begin
      if (accept) begin
         ins_ff    <= req_instruction;
         pc4_ff    <= req_pc_plus_four;
         rsv_ff    <= req_rs_regval;
         rtv_ff    <= req_rt_regval;
         exr_ff    <= req_ex_alu_result;
         fwd_rs_ff <= req_fwd_rs;
         fwd_rt_ff <= req_fwd_rt;
         squash_ff <= req_squash;
      end
   end

   always_comb begin
      op      = ins_ff[31:26];
      fn      = ins_ff[5:0];
      a       = fwd_rs_ff ? exr_ff : rsv_ff;
      b       = fwd_rt_ff ? exr_ff : rtv_ff;
      imm32   = {{(WordWidth-ImmWidth){ins_ff[ImmWidth-1]}}, ins_ff[ImmWidth-1:0]};
      btarget = pc4_ff + {imm32[WordWidth-3:0], 2'b00};
      jtarget = {pc4_ff[31:28], ins_ff[25:0], 2'b00};

      d_dest    = ins_ff[20:16];
      d_alu_src = 1'b1;
      d_mread   = 1'b0;
      d_mwrite  = 1'b0;
      d_width   = MW_NONE;
      d_rwrite  = 1'b0;
      d_taken   = 1'b0;
      d_target  = '0;

      unique case (op)
         OP_R: begin
            d_dest    = ins_ff[15:11];
            d_alu_src = 1'b0;
            if (fn == FN_JR) begin
               d_taken  = 1'b1;
               d_target = a;
            end else begin
               d_rwrite = 1'b1;
            end
         end
         OP_J: begin
            d_taken  = 1'b1;
            d_target = jtarget;
         end
         OP_JAL: begin
            d_dest   = LINK_REG;
            d_rwrite = 1'b1;
            d_taken  = 1'b1;
            d_target = jtarget;
         end
         OP_BEQ: begin
            if (a == b) begin
               d_taken  = 1'b1;
               d_target = btarget;
            end
         end
         OP_BNE: begin
            if (a != b) begin
               d_taken  = 1'b1;
               d_target = btarget;
            end
         end
         OP_BGTZ: begin
            if ((a != '0) && !a[WordWidth-1]) begin
               d_taken  = 1'b1;
               d_target = btarget;
            end
         end
         OP_ADDI, OP_ADDIU, OP_SLTI, OP_ANDI, OP_ORI, OP_NORI, OP_LUI: begin
            d_rwrite = 1'b1;
         end
         OP_LW: begin
            d_mread = 1'b1; d_rwrite = 1'b1; d_width = MW_WORD;
         end
         OP_LH: begin
            d_mread = 1'b1; d_rwrite = 1'b1; d_width = MW_HALF;
         end
         OP_LB: begin
            d_mread = 1'b1; d_rwrite = 1'b1; d_width = MW_BYTE;
         end
         OP_LHU: begin
            d_mread = 1'b1; d_rwrite = 1'b1; d_width = MW_HALFU;
         end
         OP_LBU: begin
            d_mread = 1'b1; d_rwrite = 1'b1; d_width = MW_BYTEU;
         end
         OP_SW: begin
            d_mwrite = 1'b1; d_width = MW_WORD;
         end
         OP_SH: begin
            d_mwrite = 1'b1; d_width = MW_HALF;
         end
         OP_SB: begin
            d_mwrite = 1'b1; d_width = MW_BYTE;
         end
         default: begin
         end
      endcase

      // squash zeroes every field
      if (squash_ff) begin
         rs_value_in = '0;
         rt_value_in = '0;
         imm_in      = '0;
         dest_in     = '0;
         src_imm_in  = 1'b0;
         mread_in    = 1'b0;
         mwrite_in   = 1'b0;
         width_in    = '0;
         rwrite_in   = 1'b0;
         taken_in    = 1'b0;
         target_in   = '0;
         halt_in     = 1'b0;
      end else begin
         rs_value_in = a;
         rt_value_in = b;
         imm_in      = ins_ff[ImmWidth-1:0];
         dest_in     = d_dest;
         src_imm_in  = d_alu_src;
         mread_in    = d_mread;
         mwrite_in   = d_mwrite;
         width_in    = d_width;
         rwrite_in   = d_rwrite;
         taken_in    = d_taken;
         target_in   = d_target;
         halt_in     = (op == OP_HALT);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rs_value_ff <= rs_value_in;
      rt_value_ff <= rt_value_in;
      imm_ff      <= imm_in;
      dest_ff     <= dest_in;
      alu_src_ff  <= src_imm_in;
      mread_ff    <= mread_in;
      mwrite_ff   <= mwrite_in;
      width_ff    <= width_in;
      rwrite_ff   <= rwrite_in;
      taken_ff    <= taken_in;
      target_ff   <= target_in;
      halt_ff     <= halt_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_rs_value      = rs_value_ff;
   assign rsp_rt_value      = rt_value_ff;
   assign rsp_imm_ext       = imm_ff;
   assign rsp_dest_reg      = dest_ff;
   assign rsp_alu_src       = alu_src_ff;
   assign rsp_mem_read      = mread_ff;
   assign rsp_mem_write     = mwrite_ff;
   assign rsp_mem_width     = width_ff;
   assign rsp_reg_write     = rwrite_ff;
   assign rsp_branch_taken  = taken_ff;
   assign rsp_branch_target = target_ff;
   assign rsp_halt          = halt_ff;

endmodule

// File: rtl/core/mdec_checker.sv
// Checker: port-level assertions for the decode stage, bound to the top level.
`timescale 1ns / 1ps

module mdec_checker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  start,
   input  logic                                  busy,
   input  logic                                  req_squash,
   input  logic                                  rsp_valid,
   input  logic                                  rsp_mem_read,
   input  logic                                  rsp_mem_write,
   input  mdec_pkg::mem_width_type               rsp_mem_width,
   input  logic                                  rsp_reg_write,
   input  logic                                  rsp_branch_taken,
   input  logic [mdec_pkg::WordWidth-1:0]        rsp_branch_target
);
   import mdec_pkg::*;

   // every taken item comes out through the input and result registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> ##1 rsp_valid)
      else $error("accepted item did not produce a result");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |=> ##1 !rsp_valid)
      else $error("result without an accepted item");

   a_squash_zero: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_squash) |=> ##1
         (rsp_mem_width == MW_WORD && !rsp_reg_write && !rsp_branch_taken
          && rsp_branch_target == '0))
      else $error("squashed item produced nonzero control");

   a_target_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_branch_taken) |-> rsp_branch_target == '0)
      else $error("branch target set on a not-taken item");

   a_mem_excl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mem_read) |-> (!rsp_mem_write && rsp_mem_width != MW_NONE))
      else $error("load with store or without width");

endmodule

bind mips_decode_stage_with_branch_resolve mdec_checker u_mdec_checker (
   .clock             (clock),
   .reset             (reset),
   .start             (start),
   .busy              (busy),
   .req_squash        (req_squash),
   .rsp_valid         (rsp_valid),
   .rsp_mem_read      (rsp_mem_read),
   .rsp_mem_write     (rsp_mem_write),
   .rsp_mem_width     (rsp_mem_width),
   .rsp_reg_write     (rsp_reg_write),
   .rsp_branch_taken  (rsp_branch_taken),
   .rsp_branch_target (rsp_branch_target)
);

// File: tb/sv/decode_tb_pkg.sv
// Item types and the result scoreboard for the decode stage testbench.
`timescale 1ns / 1ps

package decode_tb_pkg;

   import mdec_pkg::*;

   typedef struct packed {
      logic [31:0] instruction;
      logic [31:0] pc_plus_four;
      logic [31:0] rs_regval;
      logic [31:0] rt_regval;
      logic        fwd_rs;
      logic        fwd_rt;
      logic [31:0] ex_alu_result;
      logic        squash;
   } decode_req_type;

   typedef struct packed {
      logic [31:0]        rs_value;
      logic [31:0]        rt_value;
      logic signed [15:0] imm_ext;
      logic [4:0]         dest_reg;
      logic               alu_src;
      logic               mem_read;
      logic               mem_write;
      mem_width_type      mem_width;
      logic               reg_write;
      logic               branch_taken;
      logic [31:0]        branch_target;
      logic               halt;
   } decode_rsp_type;

   class decode_scoreboard;
      decode_rsp_type decode_expect_q[$];
      int unsigned mismatches;

      function new();
         mismatches = 0;
      endfunction

      function void report(string msg);
         // keep the log short when the block is badly off
         if (mismatches < 100) begin
            $display("[%0t] mismatch: %s", $realtime, msg);
         end
         mismatches++;
      endfunction

      function decode_rsp_type predict_decode(decode_req_type req);
         decode_rsp_type r;
         opcode_type  op;
         opcode_type  fn;
         logic [31:0] a;
         logic [31:0] b;
         logic [31:0] imm32;
         logic [31:0] offs_target;
         logic        is_load;
         r = '0;
         if (req.squash) begin
            return r;
         end
         op = req.instruction[31:26];
         fn = req.instruction[5:0];
         a = req.fwd_rs ? req.ex_alu_result : req.rs_regval;
         b = req.fwd_rt ? req.ex_alu_result : req.rt_regval;
         r.rs_value = a;
         r.rt_value = b;
         r.imm_ext = req.instruction[15:0];

         if (op == OP_R) begin
            r.dest_reg = req.instruction[15:11];
            r.alu_src = 1'b0;
         end else if (op == OP_JAL) begin
            r.dest_reg = LINK_REG;
            r.alu_src = 1'b1;
         end else begin
            r.dest_reg = req.instruction[20:16];
            r.alu_src = 1'b1;
         end

         is_load = (op == OP_LW) || (op == OP_LH) || (op == OP_LHU) ||
                   (op == OP_LB) || (op == OP_LBU);
         r.mem_read = is_load;
         r.mem_write = (op == OP_SW) || (op == OP_SH) || (op == OP_SB);

         case (op)
            OP_LW, OP_SW: r.mem_width = MW_WORD;
            OP_LH, OP_SH: r.mem_width = MW_HALF;
            OP_LB, OP_SB: r.mem_width = MW_BYTE;
            OP_LHU:       r.mem_width = MW_HALFU;
            OP_LBU:       r.mem_width = MW_BYTEU;
            default:      r.mem_width = MW_NONE;
         endcase

         if (op == OP_R) begin
            r.reg_write = (fn != FN_JR);
         end else begin
            r.reg_write = is_load || (op == OP_ADDI) || (op == OP_ADDIU) ||
                          (op == OP_LUI) || (op == OP_ANDI) || (op == OP_ORI) ||
                          (op == OP_NORI) || (op == OP_SLTI) || (op == OP_JAL);
         end

         imm32 = {{16{req.instruction[15]}}, req.instruction[15:0]};
         offs_target = req.pc_plus_four + (imm32 << 2);
         case (op)
            OP_BEQ: begin
               if (a == b) begin
                  r.branch_taken = 1'b1;
                  r.branch_target = offs_target;
               end
            end
            OP_BNE: begin
               if (a != b) begin
                  r.branch_taken = 1'b1;
                  r.branch_target = offs_target;
               end
            end
            OP_BGTZ: begin
               // signed compare against zero
               if (a != 32'd0 && !a[31]) begin
                  r.branch_taken = 1'b1;
                  r.branch_target = offs_target;
               end
            end
            OP_J, OP_JAL: begin
               r.branch_taken = 1'b1;
               r.branch_target = {req.pc_plus_four[31:28], req.instruction[25:0], 2'b00};
            end
            OP_R: begin
               if (fn == FN_JR) begin
                  r.branch_taken = 1'b1;
                  r.branch_target = a;
               end
            end
            default: ;
         endcase

         r.halt = (op == OP_HALT);
         return r;
      endfunction

      function void note_instr(decode_req_type req);
         decode_expect_q.push_back(predict_decode(req));
      endfunction

      function int pending();
         return decode_expect_q.size();
      endfunction

      function void check_field(string name, logic [31:0] got, logic [31:0] want);
         if (got !== want) begin
            report($sformatf("%s got %h, expected %h", name, got, want));
         end
      endfunction

      function void check_result(decode_rsp_type got);
         decode_rsp_type want;
         if (decode_expect_q.size() == 0) begin
            report("result arrived with no item outstanding");
            return;
         end
         want = decode_expect_q.pop_front();
         check_field("rs_value", got.rs_value, want.rs_value);
         check_field("rt_value", got.rt_value, want.rt_value);
         check_field("imm_ext", 32'(got.imm_ext), 32'(want.imm_ext));
         check_field("dest_reg", 32'(got.dest_reg), 32'(want.dest_reg));
         check_field("alu_src", 32'(got.alu_src), 32'(want.alu_src));
         check_field("mem_read", 32'(got.mem_read), 32'(want.mem_read));
         check_field("mem_write", 32'(got.mem_write), 32'(want.mem_write));
         check_field("mem_width", 32'(got.mem_width), 32'(want.mem_width));
         check_field("reg_write", 32'(got.reg_write), 32'(want.reg_write));
         check_field("branch_taken", 32'(got.branch_taken), 32'(want.branch_taken));
         check_field("branch_target", got.branch_target, want.branch_target);
         check_field("halt", 32'(got.halt), 32'(want.halt));
      endfunction
   endclass

endpackage

// File: tb/sv/testbench.sv
// Top-level testbench for the decode stage with branch resolve.
`timescale 1ns / 1ps

module testbench;

   import mdec_pkg::*;
   import decode_tb_pkg::*;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic [31:0]        req_instruction;
   logic [31:0]        req_pc_plus_four;
   logic [31:0]        req_rs_regval;
   logic [31:0]        req_rt_regval;
   logic               req_fwd_rs;
   logic               req_fwd_rt;
   logic [31:0]        req_ex_alu_result;
   logic               req_squash;
   logic               rsp_valid;
   logic [31:0]        rsp_rs_value;
   logic [31:0]        rsp_rt_value;
   logic signed [15:0] rsp_imm_ext;
   logic [4:0]         rsp_dest_reg;
   logic               rsp_alu_src;
   logic               rsp_mem_read;
   logic               rsp_mem_write;
   mem_width_type      rsp_mem_width;
   logic               rsp_reg_write;
   logic               rsp_branch_taken;
   logic [31:0]        rsp_branch_target;
   logic               rsp_halt;

   decode_scoreboard decode_board;
   decode_req_type   seen_req;
   decode_rsp_type   seen_rsp;

   mips_decode_stage_with_branch_resolve DUT (
      .clock             (clock),
      .reset             (reset),
      .start             (start),
      .busy              (busy),
      .req_instruction   (req_instruction),
      .req_pc_plus_four  (req_pc_plus_four),
      .req_rs_regval     (req_rs_regval),
      .req_rt_regval     (req_rt_regval),
      .req_fwd_rs        (req_fwd_rs),
      .req_fwd_rt        (req_fwd_rt),
      .req_ex_alu_result (req_ex_alu_result),
      .req_squash        (req_squash),
      .rsp_valid         (rsp_valid),
      .rsp_rs_value      (rsp_rs_value),
      .rsp_rt_value      (rsp_rt_value),
      .rsp_imm_ext       (rsp_imm_ext),
      .rsp_dest_reg      (rsp_dest_reg),
      .rsp_alu_src       (rsp_alu_src),
      .rsp_mem_read      (rsp_mem_read),
      .rsp_mem_write     (rsp_mem_write),
      .rsp_mem_width     (rsp_mem_width),
      .rsp_reg_write     (rsp_reg_write),
      .rsp_branch_taken  (rsp_branch_taken),
      .rsp_branch_target (rsp_branch_target),
      .rsp_halt          (rsp_halt)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("FAILURE");
      $finish;
   end

   // Sample both channels at the edge, before the block updates.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         seen_req = {req_instruction, req_pc_plus_four, req_rs_regval, req_rt_regval,
                     req_fwd_rs, req_fwd_rt, req_ex_alu_result, req_squash};
         decode_board.note_instr(seen_req);
      end
      if (!reset && rsp_valid === 1'b1) begin
         seen_rsp = {rsp_rs_value, rsp_rt_value, rsp_imm_ext, rsp_dest_reg, rsp_alu_src,
                     rsp_mem_read, rsp_mem_write, rsp_mem_width, rsp_reg_write,
                     rsp_branch_taken, rsp_branch_target, rsp_halt};
         decode_board.check_result(seen_rsp);
      end
   end

   // Offer one item, idling first at the given percentage; return at the accepting edge.
   task automatic drive_item(input decode_req_type item, input int idle_pct);
      while ($urandom_range(0, 99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start             <= 1'b1;
      req_instruction   <= item.instruction;
      req_pc_plus_four  <= item.pc_plus_four;
      req_rs_regval     <= item.rs_regval;
      req_rt_regval     <= item.rt_regval;
      req_fwd_rs        <= item.fwd_rs;
      req_fwd_rt        <= item.fwd_rt;
      req_ex_alu_result <= item.ex_alu_result;
      req_squash        <= item.squash;
      do @(posedge clock); while (busy);
   endtask

   // Hold off until every outstanding result has come back.
   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (decode_board.pending() != 0);
   endtask

   task automatic directed_item(input logic [31:0] instr, input logic [31:0] pc4,
                                input logic [31:0] rsv, input logic [31:0] rtv,
                                input logic fr, input logic ft, input logic [31:0] exr,
                                input logic sq);
      decode_req_type item;
      item = {instr, pc4, rsv, rtv, fr, ft, exr, sq};
      drive_item(item, 30);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(0, 7))
         0:       return 32'h0000_0000;
         1:       return 32'hFFFF_FFFF;
         2:       return 32'h8000_0000;
         3:       return 32'h7FFF_FFFF;
         4:       return $urandom_range(0, 15);
         default: return $urandom();
      endcase
   endfunction

   function automatic opcode_type pick_opcode();
      logic [31:0] raw;
      raw = $urandom();
      case ($urandom_range(0, 27))
         0, 1:    return OP_R;
         2:       return OP_J;
         3:       return OP_JAL;
         4, 5:    return OP_BEQ;
         6, 7:    return OP_BNE;
         8, 9:    return OP_BGTZ;
         10:      return OP_ADDI;
         11:      return OP_ADDIU;
         12:      return OP_SLTI;
         13:      return OP_ANDI;
         14:      return OP_ORI;
         15:      return OP_NORI;
         16:      return OP_LUI;
         17:      return OP_LB;
         18:      return OP_LH;
         19:      return OP_LW;
         20:      return OP_LBU;
         21:      return OP_LHU;
         22:      return OP_SB;
         23:      return OP_SH;
         24:      return OP_SW;
         25:      return OP_HALT;
         default: return raw[5:0];
      endcase
   endfunction

   function automatic decode_req_type random_item();
      decode_req_type item;
      opcode_type  op;
      logic [31:0] raw;
      op = pick_opcode();
      raw = $urandom();
      item.instruction = {op, raw[25:0]};
      if (op == OP_R && $urandom_range(0, 2) == 0) begin
         item.instruction[5:0] = FN_JR;
      end
      item.pc_plus_four  = pick_word();
      item.rs_regval     = pick_word();
      item.rt_regval     = pick_word();
      item.ex_alu_result = pick_word();
      item.fwd_rs        = 1'($urandom_range(0, 1));
      item.fwd_rt        = 1'($urandom_range(0, 1));
      item.squash        = ($urandom_range(0, 9) == 0);
      // make the compared operands equal about half the time
      if ((op == OP_BEQ || op == OP_BNE) && $urandom_range(0, 1) == 1) begin
         if (item.fwd_rt && !item.fwd_rs) begin
            item.rs_regval = item.ex_alu_result;
         end else if (!item.fwd_rt) begin
            item.rt_regval = item.fwd_rs ? item.ex_alu_result : item.rs_regval;
         end
      end
      return item;
   endfunction

   task automatic random_phase(input int count, input int idle_pct);
      for (int i = 0; i < count; i++) begin
         drive_item(random_item(), idle_pct);
      end
   endtask

   initial begin
      int wait_cycles;
      decode_board = new();
      reset             <= 1'b1;
      start             <= 1'b0;
      req_instruction   <= '0;
      req_pc_plus_four  <= '0;
      req_rs_regval     <= '0;
      req_rt_regval     <= '0;
      req_fwd_rs        <= 1'b0;
      req_fwd_rt        <= 1'b0;
      req_ex_alu_result <= '0;
      req_squash        <= 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // R-type add to rd 31, an R-type with funct 3F to rd 0, then jr
      directed_item({OP_R, 5'd1, 5'd2, 5'd31, 5'd0, 6'h20}, 32'h0000_1004,
                    32'h1234_5678, 32'h9ABC_DEF0, 1'b0, 1'b0, 32'h0, 1'b0);
      directed_item({OP_R, 5'd31, 5'd31, 5'd0, 5'd31, 6'h3F}, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 32'h0, 1'b0, 1'b1, 32'hFFFF_FFFF, 1'b0);
      directed_item({OP_R, 5'd31, 5'd0, 5'd0, 5'd0, FN_JR}, 32'h0040_0010,
                    32'h0, 32'h0, 1'b1, 1'b0, 32'hDEAD_BEE0, 1'b0);
      // beq and bne, both outcomes
      directed_item({OP_BEQ, 5'd4, 5'd5, 16'h0004}, 32'h0000_0100,
                    32'h5555_5555, 32'h5555_5555, 1'b0, 1'b0, 32'h0, 1'b0);
      directed_item({OP_BEQ, 5'd4, 5'd5, 16'hFFFF}, 32'h0000_0100,
                    32'h5555_5555, 32'hAAAA_AAAA, 1'b0, 1'b0, 32'h0, 1'b0);
      directed_item({OP_BNE, 5'd4, 5'd5, 16'h8000}, 32'h0002_0000,
                    32'h0, 32'h1, 1'b0, 1'b0, 32'h0, 1'b0);
      directed_item({OP_BNE, 5'd4, 5'd5, 16'h7FFF}, 32'h0002_0000,
                    32'h0, 32'h1, 1'b1, 1'b1, 32'h7777_7777, 1'b0);
      // bgtz: largest positive, zero, most negative
      directed_item({OP_BGTZ, 5'd6, 5'd0, 16'h0010}, 32'h1000_0000,
                    32'h7FFF_FFFF, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0);
      directed_item({OP_BGTZ, 5'd6, 5'd0, 16'h0010}, 32'h1000_0000,
                    32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0);
      directed_item({OP_BGTZ, 5'd6, 5'd0, 16'h0010}, 32'h1000_0000,
                    32'h1, 32'h0, 1'b1, 1'b0, 32'h8000_0000, 1'b0);
      // jumps keep the top four pc bits
      directed_item({OP_J, 26'h3FF_FFFF}, 32'hF000_0004,
                    32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0);
      directed_item({OP_JAL, 26'h000_0001}, 32'hA123_4568,
                    32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0);
      directed_item({OP_HALT, 26'h0}, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 1'b0);
      directed_item({6'h3E, 5'd3, 5'd9, 16'h1234}, 32'h4, 32'h1, 32'h2,
                    1'b0, 1'b0, 32'h0, 1'b0);
      // squashed items zero every field
      directed_item({OP_JAL, 26'h3FF_FFFF}, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                    32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF, 1'b1);
      directed_item({OP_HALT, 26'h3FF_FFFF}, 32'h0, 32'h0, 32'h0, 1'b0, 1'b0, 32'h0, 1'b1);
      // memory widths
      directed_item({OP_LW, 5'd1, 5'd2, 16'hFFFC}, 32'h8, 32'h100, 32'h200,
                    1'b0, 1'b0, 32'h0, 1'b0);
      directed_item({OP_LHU, 5'd1, 5'd2, 16'h0002}, 32'h8, 32'h100, 32'h200,
                    1'b0, 1'b0, 32'h0, 1'b0);
      directed_item({OP_LBU, 5'd1, 5'd2, 16'h0001}, 32'h8, 32'h100, 32'h200,
                    1'b0, 1'b0, 32'h0, 1'b0);
      directed_item({OP_SB, 5'd1, 5'd2, 16'h0003}, 32'h8, 32'h100, 32'h200,
                    1'b0, 1'b1, 32'h55, 1'b0);
      directed_item({OP_SH, 5'd1, 5'd2, 16'h0006}, 32'h8, 32'h100, 32'h200,
                    1'b1, 1'b0, 32'h66, 1'b0);
      // immediate extremes
      directed_item({OP_ADDI, 5'd7, 5'd8, 16'h8000}, 32'h0, 32'h1, 32'h2,
                    1'b0, 1'b0, 32'h0, 1'b0);
      directed_item({OP_LUI, 5'd0, 5'd31, 16'hFFFF}, 32'h0, 32'h1, 32'h2,
                    1'b0, 1'b0, 32'h0, 1'b0);
      directed_item({OP_NORI, 5'd31, 5'd0, 16'h7FFF}, 32'h0, 32'h1, 32'h2,
                    1'b0, 1'b0, 32'h0, 1'b0);
      // branch target wraps past the top of the address space
      directed_item({OP_BEQ, 5'd1, 5'd2, 16'h0010}, 32'hFFFF_FFF0, 32'h3, 32'h4,
                    1'b1, 1'b1, 32'h9, 1'b0);
      drain_results();

      random_phase(620, 30);
      drain_results();
      random_phase(620, 72);
      drain_results();
      random_phase(610, 0);
      start <= 1'b0;

      wait_cycles = 0;
      while (decode_board.pending() != 0 && wait_cycles < 200) begin
         @(posedge clock);
         wait_cycles++;
      end
      if (decode_board.pending() != 0) begin
         $display("FAILURE");
         $finish;
      end else begin
         repeat (8) @(posedge clock);
         if (decode_board.mismatches == 0) begin
            $display("SUCCESS");
         end else begin
            $display("FAILURE");
         end
         $finish;
      end
   end

endmodule
